>>> rtl/bgde_pkg.sv
package bgde_pkg;

  localparam int GLYPH_WIDTH  = 5;
  localparam int GLYPH_HEIGHT = 7;
  localparam int CELLS        = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int GX_W         = $clog2(GLYPH_WIDTH);
  localparam int GY_W         = $clog2(GLYPH_HEIGHT);
  localparam int COORD_W      = 16;
  localparam int COLOR_W      = 32;
  localparam int CHAR_W       = 8;
  localparam int ENTRY_W      = CELLS + 1;

  localparam logic [GX_W-1:0]    GX_LAST = GX_W'(GLYPH_WIDTH - 1);
  localparam logic [GY_W-1:0]    GY_LAST = GY_W'(GLYPH_HEIGHT - 1);
  localparam logic [COORD_W-1:0] ADVANCE = COORD_W'(GLYPH_WIDTH + 1);

  localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_FOLD   = 8'h20;
  localparam logic [CHAR_W-1:0] ROM_FIRST   = 8'h20;
  localparam logic [CHAR_W-1:0] ROM_LAST    = 8'h5F;

  // box outline drawn for codes the font does not cover
  localparam logic [CELLS-1:0] BORDER_CELLS =
    {5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F};

  // microprogram
  typedef logic [0:0] upc_t;
  localparam upc_t UPC_FETCH = 1'b0;
  localparam upc_t UPC_SCAN  = 1'b1;

  typedef enum logic [0:0] {
    JC_NO_REQ,
    JC_MORE
  } jump_cond_e;

  typedef struct packed {
    logic       in_ready;
    logic       load;
    logic       scan;
    logic       hold_on_stall;
    jump_cond_e cond;
    upc_t       target;
  } ctl_t;

  typedef struct packed {
    logic req;
    logic more;
    logic stall;
  } stat_t;

  function automatic ctl_t ucode(input upc_t pc);
    ctl_t w;
    w = '0;
    case (pc)
      UPC_FETCH: begin
        w.in_ready = 1'b1;
        w.load     = 1'b1;
        w.cond     = JC_NO_REQ;
        w.target   = UPC_FETCH;
      end
      UPC_SCAN: begin
        w.scan          = 1'b1;
        w.hold_on_stall = 1'b1;
        w.cond          = JC_MORE;
        w.target        = UPC_SCAN;
      end
      default: begin
        w.cond   = JC_NO_REQ;
        w.target = UPC_FETCH;
      end
    endcase
    return w;
  endfunction

  // known flag, then rows top to bottom, bit 4 of a row is the left cell
  function automatic logic [ENTRY_W-1:0] font_entry(input logic [5:0] idx);
    logic [ENTRY_W-1:0] e;
    e = '0;
    case (idx)
      6'd0:  e = {1'b1, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      6'd1:  e = {1'b1, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
      6'd2:  e = {1'b1, 5'h0A, 5'h0A, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      6'd3:  e = {1'b1, 5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h1F, 5'h0A, 5'h0A};
      6'd7:  e = {1'b1, 5'h04, 5'h04, 5'h08, 5'h00, 5'h00, 5'h00, 5'h00};
      6'd8:  e = {1'b1, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
      6'd9:  e = {1'b1, 5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
      6'd11: e = {1'b1, 5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
      6'd12: e = {1'b1, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C, 5'h08};
      6'd13: e = {1'b1, 5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      6'd14: e = {1'b1, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
      6'd15: e = {1'b1, 5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
      6'd16: e = {1'b1, 5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      6'd17: e = {1'b1, 5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      6'd18: e = {1'b1, 5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      6'd19: e = {1'b1, 5'h1E, 5'h01, 5'h01, 5'h06, 5'h01, 5'h01, 5'h1E};
      6'd20: e = {1'b1, 5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      6'd21: e = {1'b1, 5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      6'd22: e = {1'b1, 5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      6'd23: e = {1'b1, 5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      6'd24: e = {1'b1, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      6'd25: e = {1'b1, 5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      6'd26: e = {1'b1, 5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
      6'd27: e = {1'b1, 5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h08};
      6'd31: e = {1'b1, 5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
      6'd33: e = {1'b1, 5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      6'd34: e = {1'b1, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      6'd35: e = {1'b1, 5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      6'd36: e = {1'b1, 5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
      6'd37: e = {1'b1, 5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      6'd38: e = {1'b1, 5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd39: e = {1'b1, 5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      6'd40: e = {1'b1, 5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      6'd41: e = {1'b1, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      6'd42: e = {1'b1, 5'h1F, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
      6'd43: e = {1'b1, 5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      6'd44: e = {1'b1, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      6'd45: e = {1'b1, 5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      6'd46: e = {1'b1, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      6'd47: e = {1'b1, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd48: e = {1'b1, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd49: e = {1'b1, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      6'd50: e = {1'b1, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      6'd51: e = {1'b1, 5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      6'd52: e = {1'b1, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd53: e = {1'b1, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd54: e = {1'b1, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      6'd55: e = {1'b1, 5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      6'd56: e = {1'b1, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      6'd57: e = {1'b1, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd58: e = {1'b1, 5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      6'd59: e = {1'b1, 5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
      6'd61: e = {1'b1, 5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
      6'd63: e = {1'b1, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic logic [CELLS-1:0] glyph_cells(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0]  code;
    logic [ENTRY_W-1:0] e;
    code = ch;
    e    = '0;
    if (code >= LOWER_FIRST && code <= LOWER_LAST) begin
      code = code - CASE_FOLD;
    end
    if (code >= ROM_FIRST && code <= ROM_LAST) begin
      e = font_entry(6'(code - ROM_FIRST));
    end
    return e[ENTRY_W-1] ? e[CELLS-1:0] : BORDER_CELLS;
  endfunction

endpackage

>>> rtl/bgde_if.sv
interface bgde_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         character;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [31:0]        draw_color;
  logic               start_of_text;

  modport source(output valid, character, origin_x, origin_y, draw_color, start_of_text,
                 input ready);
  modport sink(input valid, character, origin_x, origin_y, draw_color, start_of_text,
               output ready);
endinterface

interface bgde_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dot_x;
  logic signed [15:0] dot_y;
  logic [31:0]        dot_color;
  logic               last_dot;

  modport source(output valid, dot_x, dot_y, dot_color, last_dot, input ready);
  modport sink(input valid, dot_x, dot_y, dot_color, last_dot, output ready);
endinterface

>>> rtl/bgde_useq.sv
module bgde_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bgde_pkg::stat_t stat_i,
  output bgde_pkg::ctl_t  ctl_o
);
  import bgde_pkg::*;

  upc_t upc_q, upc_d;
  logic taken;

  assign ctl_o = ucode(upc_q);

  always_comb begin
    case (ctl_o.cond)
      JC_NO_REQ: taken = !stat_i.req;
      JC_MORE:   taken = stat_i.more;
      default:   taken = 1'b0;
    endcase
    if (ctl_o.hold_on_stall && stat_i.stall) begin
      upc_d = upc_q;
    end else if (taken) begin
      upc_d = ctl_o.target;
    end else begin
      upc_d = upc_q + upc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> rtl/bgde_dpath.sv
module bgde_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bgde_pkg::ctl_t  ctl_i,
  output bgde_pkg::stat_t stat_o,
  bgde_in_if.sink         req_i,
  bgde_out_if.source      dot_o
);
  import bgde_pkg::*;

  logic [CELLS-1:0]   cells_q;
  logic [GX_W-1:0]    gx_q;
  logic [GY_W-1:0]    gy_q;
  logic [COORD_W-1:0] base_x_q;
  logic [COORD_W-1:0] oy_q;
  logic [COLOR_W-1:0] color_q;
  logic [COORD_W-1:0] offset_q;
  logic               out_valid_q;
  logic [COORD_W-1:0] dot_x_q;
  logic [COORD_W-1:0] dot_y_q;
  logic [COLOR_W-1:0] dot_color_q;
  logic               last_q;

  logic               load;
  logic               lit;
  logic               stall;
  logic               adv;
  logic               final_cell;
  logic [COORD_W-1:0] offset_base;

  assign req_i.ready = ctl_i.in_ready;
  assign load        = ctl_i.load && req_i.valid;
  assign lit         = cells_q[CELLS-1];
  assign stall       = ctl_i.scan && lit && out_valid_q && !dot_o.ready;
  assign adv         = ctl_i.scan && !stall;
  assign final_cell  = (gx_q == GX_LAST) && (gy_q == GY_LAST);
  assign offset_base = req_i.start_of_text ? '0 : offset_q;

  assign stat_o.req   = req_i.valid;
  assign stat_o.more  = !final_cell;
  assign stat_o.stall = stall;

  assign dot_o.valid     = out_valid_q;
  assign dot_o.dot_x     = $signed(dot_x_q);
  assign dot_o.dot_y     = $signed(dot_y_q);
  assign dot_o.dot_color = dot_color_q;
  assign dot_o.last_dot  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        offset_q <= offset_base + ADVANCE;
      end
      if (adv && lit) begin
        out_valid_q <= 1'b1;
      end else if (dot_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cells_q  <= glyph_cells(req_i.character);
      gx_q     <= '0;
      gy_q     <= '0;
      base_x_q <= COORD_W'(req_i.origin_x) + offset_base;
      oy_q     <= COORD_W'(req_i.origin_y);
      color_q  <= req_i.draw_color;
    end else if (adv) begin
      cells_q <= cells_q << 1;
      if (gx_q == GX_LAST) begin
        gx_q <= '0;
        gy_q <= gy_q + GY_W'(1);
      end else begin
        gx_q <= gx_q + GX_W'(1);
      end
    end
    if (adv && lit) begin
      dot_x_q     <= base_x_q + COORD_W'(gx_q);
      dot_y_q     <= oy_q + COORD_W'(gy_q);
      dot_color_q <= color_q;
      // last when no lit cell follows in the scan
      last_q      <= (cells_q[CELLS-2:0] == '0);
    end
  end

endmodule

>>> rtl/bitmap_glyph_dot_emitter_core.sv
// channel  | dir | fields                                                    | request
// req_i    | in  | character, origin_x, origin_y, draw_color, start_of_text  | one character
// dot_o    | out | dot_x, dot_y, dot_color, last_dot                         | one lit dot
//
// a character takes one fetch step of the microprogram, then one
// step per cell of the 5x7 box in the single-cell scan loop, unless a stall holds a step
// a lit cell waits while the sink holds the previous dot
// reset clears the step counter, the output valid and the character position
// req_i.ready is high only in the fetch step; dot_o is a one-entry output register
module bitmap_glyph_dot_emitter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  bgde_in_if.sink    req_i,
  bgde_out_if.source dot_o
);
  import bgde_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  bgde_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  bgde_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .stat_o (stat),
    .req_i  (req_i),
    .dot_o  (dot_o)
  );

endmodule

>>> rtl/bgde_checker.sv
module bgde_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] dot_x_i,
  input logic [15:0] dot_y_i,
  input logic        last_dot_i
);

  // a held dot keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(dot_x_i) && $stable(dot_y_i)
      && $stable(last_dot_i))
    else $error("dot changed while stalled");

  // one character at a time: ready drops after a request is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready stayed high after a request");

  // an idle block keeps waiting until a request arrives
  a_wait_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && !in_valid_i |=> in_ready_i)
    else $error("ready dropped without a request");

  // new dots come only from the scan, never from the fetch step
  a_dot_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("dot emitted during fetch");

endmodule

bind bitmap_glyph_dot_emitter_core bgde_checker u_bgde_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (dot_o.valid),
  .out_ready_i (dot_o.ready),
  .dot_x_i     (dot_o.dot_x),
  .dot_y_i     (dot_o.dot_y),
  .last_dot_i  (dot_o.last_dot)
);
